// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- sv/plr_pkg.sv -----
// ----------------------------------------------------------------------------
// plr_pkg
// Request kinds, status codes and item layouts of the positional list unit.
// ----------------------------------------------------------------------------
package plr_pkg;

  localparam int KIND_W      = 3;
  localparam int POS_W       = 6;
  localparam int VAL_W       = 32;
  localparam int CNT_W       = 7;
  localparam int STAT_W      = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  localparam logic [KIND_W-1:0] KIND_READ    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REPLACE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_INSERT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REMOVE  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic [1:0]       pad;
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] position;
  } in_word_t;

  typedef struct packed {
    logic [5:0]        pad;
    logic [STAT_W-1:0] status;
    logic              is_empty;
    logic [CNT_W-1:0]  element_count;
    logic [VAL_W-1:0]  read_value;
  } out_word_t;

endpackage

// ----- sv/plr_mem.sv -----
// ----------------------------------------------------------------------------
// plr_mem
// Element store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module plr_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/plr_step.sv -----
// ----------------------------------------------------------------------------
// plr_step
// Shared index unit: next index of a shift pass and whether another move is due.
// ----------------------------------------------------------------------------
module plr_step #(
  parameter int CW = 7
) (
  input  logic          up,
  input  logic [CW-1:0] cur,
  input  logic [CW-1:0] pos,
  input  logic [CW-1:0] count,
  output logic [CW-1:0] src,
  output logic          more
);

  // Removal walks upward toward the tail, insertion walks downward to the slot.
  always_comb begin
    src  = up ? (cur + CW'(1)) : (cur - CW'(1));
    more = up ? (src < count) : (cur > pos);
  end

endmodule

// ----- sv/positional_insert_remove_list_unit.sv -----
// ----------------------------------------------------------------------------
// positional_insert_remove_list_unit
// Ordered list of signed words with read, replace, insert, remove and clear.
// ----------------------------------------------------------------------------
// One request is taken at a time. Read, replace, clear and every refused
// request go through the check and done states before the next acceptance.
// Insert at position p with n elements held moves n - p words, remove moves
// n - p - 1 words: each moved word needs one read and one write of the
// element store, which has a single read port and a single write port, and the
// shared index unit steps through the moved words one per read/write pair. A
// finished result waits in an output register, so the next request is taken
// while it is still held. The store needs no clearing after reset.
module positional_insert_remove_list_unit #(
  parameter int CAPACITY  = 64,
  parameter int WORD_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [5:0] position, [37:6] value, [39:38] zero
  input  logic [plr_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [2:0] kind
  input  logic [plr_pkg::KIND_W-1:0]       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [31:0] read_value, [38:32] element_count, [39] is_empty, [41:40] status,
  // [47:42] zero
  output logic [plr_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  import plr_pkg::*;

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int AW   = $clog2(CAPACITY);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_SHIFT = 5'b00100,
    S_MOVE  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [CMPW-1:0]   pos_r, pos_nxt;
  logic [VAL_W-1:0]  value_r, value_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     cur_r, cur_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_data_r, out_data_nxt;

  in_word_t          in_word;
  logic [CMPW-1:0]   cnt_ext;
  logic              pos_lt_cnt;
  logic              pos_gt_cnt;
  logic              is_full;
  logic              no_elems;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [WORD_BITS-1:0] rd_data_r;
  logic [WORD_BITS-1:0] shift_word;
  logic [WORD_BITS-1:0] new_word;
  logic [VAL_W-1:0]  rd_ext;

  logic              step_up;
  logic [CW-1:0]     step_src;
  logic              step_more;

  assign in_word    = in_word_t'(in_tdata);
  assign cnt_ext    = CMPW'(count_r);
  assign pos_lt_cnt = pos_r < cnt_ext;
  assign pos_gt_cnt = pos_r > cnt_ext;
  assign is_full    = count_r == CW'(CAPACITY);
  assign no_elems   = count_r == '0;
  assign step_up    = kind_r == KIND_REMOVE;

  // Store the low WORD_BITS bits of a word; read back sign-extended.
  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      new_word[b] = value_r[(b < VAL_W) ? b : VAL_W - 1];
    end
    for (int b = 0; b < VAL_W; b++) begin
      rd_ext[b] = rd_data_r[(b < WORD_BITS) ? b : WORD_BITS - 1];
    end
  end

  assign shift_word = rd_data_r;

  plr_step #(
    .CW(CW)
  ) u_plr_step (
    .up    (step_up),
    .cur   (cur_r),
    .pos   (pos_r[CW-1:0]),
    .count (count_r),
    .src   (step_src),
    .more  (step_more)
  );

  plr_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .WIDTH (WORD_BITS)
  ) u_plr_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data_r)
  );

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    pos_nxt       = pos_r;
    value_nxt     = value_r;
    count_nxt     = count_r;
    cur_nxt       = cur_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = pos_r[AW-1:0];
    wr_data       = new_word;
    rd_en         = 1'b0;
    rd_addr       = pos_r[AW-1:0];

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          kind_nxt  = in_tuser;
          pos_nxt   = CMPW'(in_word.position);
          value_nxt = in_word.value;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        status_nxt = ST_OK;
        state_nxt  = S_DONE;
        unique case (kind_r)
          KIND_READ: begin
            if (pos_lt_cnt) begin
              rd_en = 1'b1;
            end else begin
              status_nxt = ST_RANGE;
            end
          end
          KIND_REPLACE: begin
            if (pos_lt_cnt) begin
              wr_en = 1'b1;
            end else begin
              status_nxt = ST_RANGE;
            end
          end
          KIND_INSERT: begin
            priority if (is_full) begin
              status_nxt = ST_FULL;
            end else if (pos_gt_cnt) begin
              status_nxt = ST_RANGE;
            end else begin
              cur_nxt   = count_r;
              state_nxt = S_SHIFT;
            end
          end
          KIND_REMOVE: begin
            priority if (no_elems) begin
              status_nxt = ST_EMPTY;
            end else if (!pos_lt_cnt) begin
              status_nxt = ST_RANGE;
            end else begin
              cur_nxt   = pos_r[CW-1:0];
              state_nxt = S_SHIFT;
            end
          end
          KIND_CLEAR: begin
            count_nxt = '0;
          end
          default: begin
          end
        endcase
      end
      S_SHIFT: begin
        if (step_more) begin
          rd_en     = 1'b1;
          rd_addr   = step_src[AW-1:0];
          state_nxt = S_MOVE;
        end else begin
          if (step_up) begin
            count_nxt = count_r - CW'(1);
          end else begin
            wr_en     = 1'b1;
            count_nxt = count_r + CW'(1);
          end
          state_nxt = S_DONE;
        end
      end
      S_MOVE: begin
        wr_en     = 1'b1;
        wr_addr   = cur_r[AW-1:0];
        wr_data   = shift_word;
        cur_nxt   = step_src;
        state_nxt = S_SHIFT;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.pad           = '0;
          out_data_nxt.status        = status_r;
          out_data_nxt.is_empty      = no_elems;
          out_data_nxt.element_count = CNT_W'(count_r);
          out_data_nxt.read_value    =
            (kind_r == KIND_READ && status_r == ST_OK) ? rd_ext : '0;
          state_nxt                  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    pos_r      <= pos_nxt;
    value_r    <= value_nxt;
    cur_r      <= cur_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- sv/plr_checker.sv -----
// ----------------------------------------------------------------------------
// plr_checker
// Port-level checks of the positional list unit, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module plr_checker #(
  parameter int CAPACITY = 64
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [plr_pkg::OUT_TDATA_W-1:0] out_tdata
);

  import plr_pkg::*;

  out_word_t ow;

  assign ow = out_word_t'(out_tdata);

  // A held result must not change while the consumer stalls.
  `ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // The unit works on one request at a time.
  `ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)

  `ASSERT_IMPLIES(a_empty_count, out_tvalid && ow.is_empty, ow.element_count == '0)

  // Only a successful read returns a word.
  `ASSERT_IMPLIES(a_refused_no_data, out_tvalid && ow.status != ST_OK, ow.read_value == '0)

  `ASSERT_IMPLIES(a_count_bound, out_tvalid, 32'(ow.element_count) <= CAPACITY)

endmodule

bind positional_insert_remove_list_unit plr_checker #(
  .CAPACITY(CAPACITY)
) u_plr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- test/tb_positional_insert_remove_list_unit.sv -----
// ----------------------------------------------------------------------------
// tb_positional_insert_remove_list_unit
// Self-checking testbench for the positional insert/remove list unit.
// ----------------------------------------------------------------------------
// A short table of directed requests covers the range and empty codes, the
// word extremes and the unused kinds. A random part follows. It first tries
// to fill the list, then to drain it, then runs mixed traffic. Every accepted
// request goes through a behavioral list model, and each result is compared
// field by field with the oldest expected result. Both stream sides idle in
// random bursts, except during calm stretches and at the end of the run.
// ----------------------------------------------------------------------------
module tb_positional_insert_remove_list_unit;
  import plr_pkg::*;

  localparam int CAPACITY     = 64;
  localparam int RANDOM_ITEMS = 500;
  localparam int QUIET_ITEMS  = 80;
  localparam int IDLE_LIMIT   = 4000;
  localparam int TAIL_CYCLES  = 20;

  // Kinds that the unit ignores. They still give a result.
  localparam logic [KIND_W-1:0] KIND_SPARE5 = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE7 = 3'd7;

  typedef enum {MIX_GROW, MIX_SHRINK, MIX_ANY} traffic_mix_t;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  pos;
    logic [VAL_W-1:0]  value;
    bit                typed;
    out_word_t         want;
  } dir_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [KIND_W-1:0]      in_tuser;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  logic [VAL_W-1:0] list_words [CAPACITY];
  int               list_len;
  out_word_t        expected_results [$];
  int               error_count = 0;
  int               idle_cycles = 0;
  int               stall_left = 0;
  bit               calm;
  bit               quiet;

  // Rows with want filled in check the typed result; the others use the model.
  dir_row_t dir_rows [25] = '{
    '{KIND_READ,    6'd0,  32'd0,          1'b1, '{6'd0, ST_RANGE, 1'b1, 7'd0, 32'd0}},
    '{KIND_REMOVE,  6'd0,  32'd0,          1'b1, '{6'd0, ST_EMPTY, 1'b1, 7'd0, 32'd0}},
    '{KIND_REPLACE, 6'd0,  32'h1234_5678,  1'b1, '{6'd0, ST_RANGE, 1'b1, 7'd0, 32'd0}},
    '{KIND_INSERT,  6'd1,  32'h0000_0001,  1'b1, '{6'd0, ST_RANGE, 1'b1, 7'd0, 32'd0}},
    '{KIND_INSERT,  6'd0,  32'h8000_0000,  1'b1, '{6'd0, ST_OK,    1'b0, 7'd1, 32'd0}},
    '{KIND_INSERT,  6'd1,  32'h7fff_ffff,  1'b1, '{6'd0, ST_OK,    1'b0, 7'd2, 32'd0}},
    '{KIND_READ,    6'd0,  32'd0,          1'b1,
      '{6'd0, ST_OK, 1'b0, 7'd2, 32'h8000_0000}},
    '{KIND_READ,    6'd1,  32'd0,          1'b1,
      '{6'd0, ST_OK, 1'b0, 7'd2, 32'h7fff_ffff}},
    '{KIND_INSERT,  6'd1,  32'd0,          1'b0, '0},
    '{KIND_INSERT,  6'd0,  32'hffff_ffff,  1'b0, '0},
    '{KIND_READ,    6'd63, 32'd0,          1'b1, '{6'd0, ST_RANGE, 1'b0, 7'd4, 32'd0}},
    '{KIND_REPLACE, 6'd2,  32'h5a5a_5a5a,  1'b0, '0},
    '{KIND_READ,    6'd2,  32'd0,          1'b0, '0},
    '{KIND_REMOVE,  6'd4,  32'd0,          1'b1, '{6'd0, ST_RANGE, 1'b0, 7'd4, 32'd0}},
    '{KIND_INSERT,  6'd5,  32'h0000_0002,  1'b1, '{6'd0, ST_RANGE, 1'b0, 7'd4, 32'd0}},
    '{KIND_SPARE5,  6'd0,  32'd0,          1'b1, '{6'd0, ST_OK,    1'b0, 7'd4, 32'd0}},
    '{KIND_SPARE7,  6'd63, 32'hffff_ffff,  1'b1, '{6'd0, ST_OK,    1'b0, 7'd4, 32'd0}},
    '{KIND_SPARE6,  6'd21, 32'h0f0f_0f0f,  1'b1, '{6'd0, ST_OK,    1'b0, 7'd4, 32'd0}},
    '{KIND_REMOVE,  6'd0,  32'd0,          1'b0, '0},
    '{KIND_REMOVE,  6'd2,  32'd0,          1'b0, '0},
    '{KIND_READ,    6'd0,  32'd0,          1'b0, '0},
    '{KIND_CLEAR,   6'd0,  32'd0,          1'b1, '{6'd0, ST_OK,    1'b1, 7'd0, 32'd0}},
    '{KIND_READ,    6'd0,  32'd0,          1'b1, '{6'd0, ST_RANGE, 1'b1, 7'd0, 32'd0}},
    '{KIND_REMOVE,  6'd0,  32'd0,          1'b1, '{6'd0, ST_EMPTY, 1'b1, 7'd0, 32'd0}},
    '{KIND_INSERT,  6'd0,  32'h0000_0001,  1'b0, '0}
  };

  positional_insert_remove_list_unit #(
    .CAPACITY (CAPACITY),
    .WORD_BITS(VAL_W)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Applies one request to the list model and returns the result it gives.
  function automatic out_word_t list_apply(logic [KIND_W-1:0] kind,
                                           logic [POS_W-1:0] pos,
                                           logic [VAL_W-1:0] value);
    out_word_t res;
    int        i;
    res = '0;
    res.status = ST_OK;
    case (kind)
      KIND_READ: begin
        if (pos < list_len) res.read_value = list_words[pos];
        else res.status = ST_RANGE;
      end
      KIND_REPLACE: begin
        if (pos < list_len) list_words[pos] = value;
        else res.status = ST_RANGE;
      end
      KIND_INSERT: begin
        if (list_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else if (pos > list_len) begin
          res.status = ST_RANGE;
        end else begin
          for (i = list_len; i > pos; i--) list_words[i] = list_words[i-1];
          list_words[pos] = value;
          list_len++;
        end
      end
      KIND_REMOVE: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else if (pos >= list_len) begin
          res.status = ST_RANGE;
        end else begin
          for (i = pos; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
        end
      end
      KIND_CLEAR: begin
        list_len = 0;
      end
      default: begin
      end
    endcase
    res.element_count = list_len[CNT_W-1:0];
    res.is_empty      = (list_len == 0);
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch in %s at %0t: got %0h, expected %0h", field, $time, got, want);
    error_count++;
  endtask

  // Drives one request, waits until it is taken and records its result.
  task automatic send_request(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos,
                              logic [VAL_W-1:0] value, bit typed, out_word_t want);
    in_word_t  word;
    out_word_t pred;
    int        gap;
    gap = (calm || quiet || $urandom_range(0, 4) != 0) ? 0 : $urandom_range(1, 10);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    word          = '0;
    word.position = pos;
    word.value    = value;
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    in_tuser  <= kind;
    do @(posedge clk); while (!in_tready);
    pred = list_apply(kind, pos, value);
    expected_results.push_back(typed ? want : pred);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int               n;
    int               k;
    int               seg_idx;
    int               seg_len;
    int               pick;
    traffic_mix_t     mix;
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  pos;
    logic [VAL_W-1:0]  value;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    list_len    = 0;
    calm        = 1'b0;
    quiet       = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[r])
      send_request(dir_rows[r].kind, dir_rows[r].pos, dir_rows[r].value,
                   dir_rows[r].typed, dir_rows[r].want);
    drain_results();

    // Aim at a full list first, then at an empty one, then mixed segments.
    n       = 0;
    seg_idx = 0;
    while (n < RANDOM_ITEMS) begin
      if (seg_idx == 0) begin
        mix     = MIX_GROW;
        seg_len = 110;
      end else if (seg_idx == 1) begin
        mix     = MIX_SHRINK;
        seg_len = 110;
      end else begin
        pick    = $urandom_range(0, 2);
        mix     = (pick == 0) ? MIX_GROW : (pick == 1) ? MIX_SHRINK : MIX_ANY;
        seg_len = $urandom_range(30, 70);
      end
      calm = (seg_idx > 1 && $urandom_range(0, 3) == 0);
      for (k = 0; k < seg_len && n < RANDOM_ITEMS; k++, n++) begin
        quiet = (n >= RANDOM_ITEMS - QUIET_ITEMS);
        pick  = $urandom_range(0, 99);
        if (mix == MIX_GROW && pick < 85) begin
          kind = KIND_INSERT;
        end else if (mix == MIX_SHRINK && pick < 85) begin
          kind = KIND_REMOVE;
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 4 && mix == MIX_ANY) kind = KIND_CLEAR;
          else if (pick < 8) kind = KIND_W'($urandom_range(KIND_SPARE5, KIND_SPARE7));
          else kind = KIND_W'($urandom_range(KIND_READ, KIND_REMOVE));
        end
        if ($urandom_range(0, 6) == 0) pos = POS_W'($urandom_range(0, 63));
        else if (kind == KIND_INSERT) pos = POS_W'($urandom_range(0, list_len));
        else if (list_len > 0) pos = POS_W'($urandom_range(0, list_len - 1));
        else pos = '0;
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 3))
            0: value = 32'h8000_0000;
            1: value = 32'h7fff_ffff;
            2: value = 32'h0000_0000;
            default: value = 32'hffff_ffff;
          endcase
        end else begin
          value = $urandom;
        end
        send_request(kind, pos, value, 1'b0, '0);
      end
      // Hold the sender once in mid-run until every result is back.
      if (seg_idx == 2) drain_results();
      seg_idx++;
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("[positional_insert_remove_list_unit] OK");
    end else begin
      $display("[positional_insert_remove_list_unit] ERROR");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (rst_n && !calm && !quiet && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 9);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    out_word_t got;
    out_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_results.size() == 0) begin
        report_mismatch("result with none expected", got.read_value, '0);
      end else begin
        want = expected_results.pop_front();
        if (got.read_value !== want.read_value)
          report_mismatch("read_value", got.read_value, want.read_value);
        if (got.element_count !== want.element_count)
          report_mismatch("element_count", 32'(got.element_count),
                          32'(want.element_count));
        if (got.is_empty !== want.is_empty)
          report_mismatch("is_empty", 32'(got.is_empty), 32'(want.is_empty));
        if (got.status !== want.status)
          report_mismatch("status", 32'(got.status), 32'(want.status));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[positional_insert_remove_list_unit] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
